FILE: sv/ciep_pkg.sv
// types and constants shared by the connection info element parser
package ciep_pkg;

  // parse position within one element
  typedef enum logic [3:0] {
    PH_TYPE  = 4'd0,
    PH_LEN   = 4'd1,
    PH_MED   = 4'd2,
    PH_MASK  = 4'd3,
    PH_MAC   = 4'd4,
    PH_CLEN  = 4'd5,
    PH_CDATA = 4'd6,
    PH_PSM   = 4'd7,
    PH_ACT   = 4'd8,
    PH_SKIP  = 4'd9
  } phase_t;

  // field class codes
  localparam logic [2:0] CLS_HEADER = 3'd0;
  localparam logic [2:0] CLS_MAC    = 3'd1;
  localparam logic [2:0] CLS_CLEN   = 3'd2;
  localparam logic [2:0] CLS_CDATA  = 3'd3;
  localparam logic [2:0] CLS_PSM    = 3'd4;
  localparam logic [2:0] CLS_ACTION = 3'd5;

  // status codes, reported on the final byte
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_TYPE      = 4'd2;
  localparam logic [3:0] ST_LENGTH    = 4'd3;
  localparam logic [3:0] ST_MEDIUM    = 4'd4;
  localparam logic [3:0] ST_MAC       = 4'd5;
  localparam logic [3:0] ST_CHAR      = 4'd6;
  localparam logic [3:0] ST_PSM       = 4'd7;
  localparam logic [3:0] ST_NO_ACTION = 4'd8;

  // configuration register indexes
  localparam logic [1:0] CFG_ELEMENT_TYPE = 2'd0;
  localparam logic [1:0] CFG_MEDIUM_TYPE  = 2'd1;
  localparam logic [1:0] CFG_MIN_LENGTH   = 2'd2;

  // presence mask bits in the mask byte
  localparam int MASK_MAC_BIT  = 6;
  localparam int MASK_CHAR_BIT = 5;
  localparam int MASK_PSM_BIT  = 4;

  // header bytes (type and length) that the length byte does not count
  localparam logic [7:0] HDR_LEN_ADJ = 8'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] field_class;
    logic [7:0] data_byte;
    logic [6:0] field_offset;
    logic       has_mac;
    logic       has_char;
    logic       has_psm;
    logic       element_done;
    logic [3:0] status;
  } out_item_t;

endpackage

FILE: sv/connection_info_element_parser_unit.sv
// connection info element parser: labels each byte of an element and checks its header
//
// Usage: bytes of one element enter on the in_ channel (valid/ready), one per item,
// with final_byte set on the last byte. Every input item yields exactly one result
// item on the out_ channel carrying the byte, its field class, its offset within the
// field and the presence bits seen so far. The status field is nonzero only on the
// result of the final byte and reports the first failing check of the element.
// An accepted item is offered as a result in the cycle after it is taken. Throughput
// is one item per cycle unless the receiver stalls; the per-byte state update is a
// single level of compare and increment logic between the parse state registers
// and the result register. in_ready stays high while the result register is empty
// or being taken, so a stalled receiver holds the result and back-pressures the input
// after one item. Synchronous active-low reset returns the parser to the start of an
// element, empties the result register and sets the registers to type 0, medium 0
// and minimum length 4. Configuration writes (cfg_we, cfg_index, cfg_wdata) take
// effect at the edge and should be made while no element is in progress.
module connection_info_element_parser_unit #(
  parameter int MAC_BYTES = 6,
  parameter int PSM_BYTES = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ciep_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ciep_pkg::out_item_t   out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_wdata
);

  localparam logic [7:0] MacLast = 8'(MAC_BYTES);
  localparam logic [7:0] PsmLast = 8'(PSM_BYTES);

  // configuration registers
  logic [7:0] elem_type_r;
  logic [7:0] med_type_r;
  logic [7:0] min_len_r;

  // element state
  ciep_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] decl_len_r, decl_len_nxt;
  logic [2:0] presence_r, presence_nxt;
  logic [7:0] field_cnt_r, field_cnt_nxt;
  logic [7:0] char_len_r, char_len_nxt;
  logic       err_type_r, err_type_nxt;
  logic       err_med_r, err_med_nxt;

  // result register
  logic                out_valid_r;
  ciep_pkg::out_item_t out_data_r, out_data_nxt;

  logic in_fire;
  ciep_pkg::phase_t phase_upd;
  logic [7:0] cnt_upd;
  logic [7:0] dl_upd;
  logic [7:0] fc_upd;
  logic [2:0] pres_upd;
  logic [2:0] cls;
  logic [6:0] off;
  logic [3:0] status;
  logic       et_upd, em_upd;
  ciep_pkg::phase_t after_char, after_mac, after_mask;
  logic [2:0] mask_flags;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_type_r <= 8'd0;
      med_type_r  <= 8'd0;
      min_len_r   <= 8'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ciep_pkg::CFG_ELEMENT_TYPE: elem_type_r <= cfg_wdata;
        ciep_pkg::CFG_MEDIUM_TYPE:  med_type_r  <= cfg_wdata;
        ciep_pkg::CFG_MIN_LENGTH:   min_len_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // successor phases once a field ends
  assign mask_flags = {in_data.in_byte[ciep_pkg::MASK_MAC_BIT],
                       in_data.in_byte[ciep_pkg::MASK_CHAR_BIT],
                       in_data.in_byte[ciep_pkg::MASK_PSM_BIT]};
  assign after_char = presence_r[0] ? ciep_pkg::PH_PSM : ciep_pkg::PH_ACT;
  assign after_mac  = presence_r[1] ? ciep_pkg::PH_CLEN : after_char;
  always_comb begin
    if (mask_flags[2]) begin
      after_mask = ciep_pkg::PH_MAC;
    end else if (mask_flags[1]) begin
      after_mask = ciep_pkg::PH_CLEN;
    end else if (mask_flags[0]) begin
      after_mask = ciep_pkg::PH_PSM;
    end else begin
      after_mask = ciep_pkg::PH_ACT;
    end
  end

  // per-byte parse step
  always_comb begin
    phase_upd = phase_r;
    dl_upd    = decl_len_r;
    fc_upd    = field_cnt_r;
    pres_upd  = presence_r;
    et_upd    = err_type_r;
    em_upd    = err_med_r;
    char_len_nxt = char_len_r;
    cls = ciep_pkg::CLS_HEADER;
    off = (field_cnt_r > 8'd127) ? 7'd127 : field_cnt_r[6:0];
    cnt_upd = (byte_count_r == 8'hff) ? byte_count_r : byte_count_r + 8'd1;
    unique case (phase_r)
      ciep_pkg::PH_TYPE: begin
        off = 7'd0;
        if (in_data.in_byte != elem_type_r) et_upd = 1'b1;
        phase_upd = ciep_pkg::PH_LEN;
      end
      ciep_pkg::PH_LEN: begin
        off = 7'd1;
        dl_upd = in_data.in_byte;
        phase_upd = ciep_pkg::PH_MED;
      end
      ciep_pkg::PH_MED: begin
        off = 7'd2;
        if (in_data.in_byte != med_type_r) em_upd = 1'b1;
        phase_upd = ciep_pkg::PH_MASK;
      end
      ciep_pkg::PH_MASK: begin
        off = 7'd3;
        pres_upd = mask_flags;
        fc_upd = 8'd0;
        phase_upd = after_mask;
      end
      ciep_pkg::PH_MAC: begin
        cls = ciep_pkg::CLS_MAC;
        fc_upd = field_cnt_r + 8'd1;
        if (fc_upd >= MacLast) begin
          fc_upd = 8'd0;
          phase_upd = after_mac;
        end
      end
      ciep_pkg::PH_CLEN: begin
        cls = ciep_pkg::CLS_CLEN;
        off = 7'd0;
        fc_upd = 8'd0;
        if (in_data.in_byte[7]) begin
          phase_upd = ciep_pkg::PH_SKIP;
        end else begin
          char_len_nxt = in_data.in_byte;
          phase_upd = (in_data.in_byte == 8'd0) ? after_char : ciep_pkg::PH_CDATA;
        end
      end
      ciep_pkg::PH_CDATA: begin
        cls = ciep_pkg::CLS_CDATA;
        fc_upd = field_cnt_r + 8'd1;
        if (fc_upd >= char_len_r) begin
          fc_upd = 8'd0;
          phase_upd = after_char;
        end
      end
      ciep_pkg::PH_SKIP: begin
        cls = ciep_pkg::CLS_CDATA;
        if (field_cnt_r < 8'd127) fc_upd = field_cnt_r + 8'd1;
      end
      ciep_pkg::PH_PSM: begin
        cls = ciep_pkg::CLS_PSM;
        fc_upd = field_cnt_r + 8'd1;
        if (fc_upd >= PsmLast) begin
          fc_upd = 8'd0;
          phase_upd = ciep_pkg::PH_ACT;
        end
      end
      default: begin
        cls = ciep_pkg::CLS_ACTION;
        if (field_cnt_r != 8'hff) fc_upd = field_cnt_r + 8'd1;
      end
    endcase
  end

  // end-of-element status, first failing check wins
  always_comb begin
    if (cnt_upd < min_len_r) begin
      status = ciep_pkg::ST_SHORT;
    end else if (et_upd) begin
      status = ciep_pkg::ST_TYPE;
    end else if (cnt_upd < 8'd2 || dl_upd[7] || dl_upd != cnt_upd - ciep_pkg::HDR_LEN_ADJ) begin
      status = ciep_pkg::ST_LENGTH;
    end else if (cnt_upd < 8'd3 || em_upd) begin
      status = ciep_pkg::ST_MEDIUM;
    end else begin
      case (phase_upd)
        ciep_pkg::PH_MAC: status = ciep_pkg::ST_MAC;
        ciep_pkg::PH_CLEN, ciep_pkg::PH_CDATA, ciep_pkg::PH_SKIP: status = ciep_pkg::ST_CHAR;
        ciep_pkg::PH_PSM: status = ciep_pkg::ST_PSM;
        ciep_pkg::PH_ACT: status = (fc_upd == 8'd0) ? ciep_pkg::ST_NO_ACTION
                                                    : ciep_pkg::ST_OK;
        default: status = ciep_pkg::ST_NO_ACTION;
      endcase
    end
  end

  // result item and element restart on the final byte
  always_comb begin
    out_data_nxt.field_class  = cls;
    out_data_nxt.data_byte    = in_data.in_byte;
    out_data_nxt.field_offset = off;
    out_data_nxt.has_mac      = pres_upd[2];
    out_data_nxt.has_char     = pres_upd[1];
    out_data_nxt.has_psm      = pres_upd[0];
    out_data_nxt.element_done = in_data.final_byte;
    out_data_nxt.status       = in_data.final_byte ? status : ciep_pkg::ST_OK;
    if (in_data.final_byte) begin
      phase_nxt      = ciep_pkg::PH_TYPE;
      byte_count_nxt = 8'd0;
      decl_len_nxt   = 8'd0;
      presence_nxt   = 3'd0;
      field_cnt_nxt  = 8'd0;
      err_type_nxt   = 1'b0;
      err_med_nxt    = 1'b0;
    end else begin
      phase_nxt      = phase_upd;
      byte_count_nxt = cnt_upd;
      decl_len_nxt   = dl_upd;
      presence_nxt   = pres_upd;
      field_cnt_nxt  = fc_upd;
      err_type_nxt   = et_upd;
      err_med_nxt    = em_upd;
    end
  end

  // element state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ciep_pkg::PH_TYPE;
      byte_count_r <= 8'd0;
      decl_len_r   <= 8'd0;
      presence_r   <= 3'd0;
      field_cnt_r  <= 8'd0;
      char_len_r   <= 8'd0;
      err_type_r   <= 1'b0;
      err_med_r    <= 1'b0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      decl_len_r   <= decl_len_nxt;
      presence_r   <= presence_nxt;
      field_cnt_r  <= field_cnt_nxt;
      char_len_r   <= in_data.final_byte ? 8'd0 : char_len_nxt;
      err_type_r   <= err_type_nxt;
      err_med_r    <= err_med_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // final byte restarts the element
  a_final_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.final_byte) |=>
      (phase_r == ciep_pkg::PH_TYPE && byte_count_r == 8'd0 && presence_r == 3'd0))
    else $error("element state not cleared after final byte");

  // status only on the final result
  a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.element_done || out_data_r.status == ciep_pkg::ST_OK))
    else $error("status reported on a non-final item");

  // no presence bits before the mask byte
  a_presence_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ciep_pkg::PH_TYPE || phase_r == ciep_pkg::PH_LEN ||
     phase_r == ciep_pkg::PH_MED || phase_r == ciep_pkg::PH_MASK) |-> (presence_r == 3'd0))
    else $error("presence bits set during header");

  // skipped characteristic counter saturates
  a_skip_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ciep_pkg::PH_SKIP) |-> (field_cnt_r <= 8'd127))
    else $error("skip counter past saturation");

  // empty result register never blocks input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

FILE: sim/connection_info_element_parser_unit_tb.sv
// testbench for the connection info element parser: directed and random elements, self-checked
`timescale 1ns / 100ps

module connection_info_element_parser_unit_tb;

  localparam int MAC_LEN = 6;
  localparam int PSM_LEN = 2;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ciep_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ciep_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = ciep_pkg::CFG_ELEMENT_TYPE;
  logic [7:0]          cfg_wdata = 8'h00;

  // shadow of the configuration registers
  logic [7:0] reg_type = 8'h00;
  logic [7:0] reg_medium = 8'h00;
  logic [7:0] reg_min = 8'd4;

  // parser state as predicted
  ciep_pkg::phase_t cur_phase = ciep_pkg::PH_TYPE;
  logic [7:0] byte_total = 8'd0;
  logic [7:0] decl_len = 8'd0;
  logic [2:0] presence = 3'b000;
  logic [7:0] field_pos = 8'd0;
  logic [7:0] char_len = 8'd0;
  logic       bad_type = 1'b0;
  logic       bad_medium = 1'b0;

  ciep_pkg::out_item_t expected_labels[$];
  logic [7:0] elem_bytes[$];
  int         mismatch_count = 0;
  int         sent_items = 0;
  logic       steady = 1'b0;

  connection_info_element_parser_unit #(
    .MAC_BYTES(MAC_LEN),
    .PSM_BYTES(PSM_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 20);
  end

  function automatic logic [6:0] sat7(input logic [7:0] v);
    return (v > 8'd127) ? 7'd127 : v[6:0];
  endfunction

  function automatic ciep_pkg::phase_t after_char();
    return presence[0] ? ciep_pkg::PH_PSM : ciep_pkg::PH_ACT;
  endfunction

  function automatic ciep_pkg::phase_t after_mac();
    return presence[1] ? ciep_pkg::PH_CLEN : after_char();
  endfunction

  // label one byte and advance the predicted parse state
  function automatic ciep_pkg::out_item_t parse_byte(input ciep_pkg::in_item_t it);
    ciep_pkg::out_item_t r;
    logic [7:0] b;
    logic [2:0] cls;
    logic [6:0] off;
    logic [3:0] st;
    b = it.in_byte;
    cls = ciep_pkg::CLS_HEADER;
    off = 7'd0;
    st = ciep_pkg::ST_OK;
    if (byte_total != 8'hFF) byte_total = byte_total + 8'd1;

    case (cur_phase)
      ciep_pkg::PH_TYPE: begin
        off = 7'd0;
        if (b != reg_type) bad_type = 1'b1;
        cur_phase = ciep_pkg::PH_LEN;
      end
      ciep_pkg::PH_LEN: begin
        off = 7'd1;
        decl_len = b;
        cur_phase = ciep_pkg::PH_MED;
      end
      ciep_pkg::PH_MED: begin
        off = 7'd2;
        if (b != reg_medium) bad_medium = 1'b1;
        cur_phase = ciep_pkg::PH_MASK;
      end
      ciep_pkg::PH_MASK: begin
        off = 7'd3;
        presence = {b[ciep_pkg::MASK_MAC_BIT], b[ciep_pkg::MASK_CHAR_BIT],
                    b[ciep_pkg::MASK_PSM_BIT]};
        field_pos = 8'd0;
        cur_phase = presence[2] ? ciep_pkg::PH_MAC : after_mac();
      end
      ciep_pkg::PH_MAC: begin
        cls = ciep_pkg::CLS_MAC;
        off = sat7(field_pos);
        field_pos = field_pos + 8'd1;
        if (field_pos >= MAC_LEN) begin
          field_pos = 8'd0;
          cur_phase = after_mac();
        end
      end
      ciep_pkg::PH_CLEN: begin
        cls = ciep_pkg::CLS_CLEN;
        off = 7'd0;
        field_pos = 8'd0;
        if (b >= 8'd128) begin
          cur_phase = ciep_pkg::PH_SKIP;
        end else begin
          char_len = b;
          cur_phase = (b == 8'd0) ? after_char() : ciep_pkg::PH_CDATA;
        end
      end
      ciep_pkg::PH_CDATA: begin
        cls = ciep_pkg::CLS_CDATA;
        off = sat7(field_pos);
        field_pos = field_pos + 8'd1;
        if (field_pos >= char_len) begin
          field_pos = 8'd0;
          cur_phase = after_char();
        end
      end
      ciep_pkg::PH_SKIP: begin
        cls = ciep_pkg::CLS_CDATA;
        off = sat7(field_pos);
        if (field_pos < 8'd127) field_pos = field_pos + 8'd1;
      end
      ciep_pkg::PH_PSM: begin
        cls = ciep_pkg::CLS_PSM;
        off = sat7(field_pos);
        field_pos = field_pos + 8'd1;
        if (field_pos >= PSM_LEN) begin
          field_pos = 8'd0;
          cur_phase = ciep_pkg::PH_ACT;
        end
      end
      default: begin
        cls = ciep_pkg::CLS_ACTION;
        off = sat7(field_pos);
        if (field_pos != 8'hFF) field_pos = field_pos + 8'd1;
      end
    endcase

    // status: first failing check of the element
    if (it.final_byte) begin
      if (byte_total < reg_min) st = ciep_pkg::ST_SHORT;
      else if (bad_type) st = ciep_pkg::ST_TYPE;
      else if (!(byte_total >= 8'd2 && decl_len < 8'd128 &&
                 decl_len == byte_total - ciep_pkg::HDR_LEN_ADJ)) st = ciep_pkg::ST_LENGTH;
      else if (byte_total < 8'd3 || bad_medium) st = ciep_pkg::ST_MEDIUM;
      else begin
        case (cur_phase)
          ciep_pkg::PH_MAC:  st = ciep_pkg::ST_MAC;
          ciep_pkg::PH_CLEN, ciep_pkg::PH_CDATA, ciep_pkg::PH_SKIP: st = ciep_pkg::ST_CHAR;
          ciep_pkg::PH_PSM:  st = ciep_pkg::ST_PSM;
          ciep_pkg::PH_ACT:  st = (field_pos == 8'd0) ? ciep_pkg::ST_NO_ACTION
                                                       : ciep_pkg::ST_OK;
          default:           st = ciep_pkg::ST_NO_ACTION;
        endcase
      end
    end

    r.field_class  = cls;
    r.data_byte    = b;
    r.field_offset = off;
    r.has_mac      = presence[2];
    r.has_char     = presence[1];
    r.has_psm      = presence[0];
    r.element_done = it.final_byte;
    r.status       = st;

    // a final byte returns the parser to the start of an element
    if (it.final_byte) begin
      cur_phase = ciep_pkg::PH_TYPE;
      byte_total = 8'd0;
      decl_len = 8'd0;
      presence = 3'b000;
      field_pos = 8'd0;
      char_len = 8'd0;
      bad_type = 1'b0;
      bad_medium = 1'b0;
    end
    return r;
  endfunction

  // compare each result with the oldest label, then record the label of any accepted byte
  always @(posedge clk) begin : check_labels
    ciep_pkg::out_item_t want;
    logic      bad;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_labels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with no label waiting: %h", $realtime, out_data);
        end else begin
          want = expected_labels.pop_front();
          bad = (want.field_class  !== out_data.field_class)  ||
                (want.data_byte    !== out_data.data_byte)    ||
                (want.field_offset !== out_data.field_offset) ||
                (want.has_mac      !== out_data.has_mac)      ||
                (want.has_char     !== out_data.has_char)     ||
                (want.has_psm      !== out_data.has_psm)      ||
                (want.element_done !== out_data.element_done) ||
                (want.status       !== out_data.status);
          if (bad) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch exp cls=%0d byte=%h off=%0d m/c/p=%b%b%b done=%b st=%0d",
                       $realtime, want.field_class, want.data_byte, want.field_offset,
                       want.has_mac, want.has_char, want.has_psm, want.element_done,
                       want.status,
                       "\n          got cls=%0d byte=%h off=%0d m/c/p=%b%b%b done=%b st=%0d",
                       out_data.field_class, out_data.data_byte, out_data.field_offset,
                       out_data.has_mac, out_data.has_char, out_data.has_psm,
                       out_data.element_done, out_data.status);
          end
        end
      end
      if (in_valid && in_ready)
        expected_labels.insert(expected_labels.size(), parse_byte(in_data));
    end
  end

  // send one byte, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{in_byte: b, final_byte: fin};
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  task automatic send_element();
    for (int i = 0; i < elem_bytes.size(); i++)
      send_byte(elem_bytes[i], i == elem_bytes.size() - 1);
  endtask

  // wait until every label has been matched
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_labels.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ciep_pkg::CFG_ELEMENT_TYPE: reg_type = val;
      ciep_pkg::CFG_MEDIUM_TYPE:  reg_medium = val;
      ciep_pkg::CFG_MIN_LENGTH:   reg_min = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [7:0] t, input logic [7:0] m, input logic [7:0] n);
    write_reg(ciep_pkg::CFG_ELEMENT_TYPE, t);
    write_reg(ciep_pkg::CFG_MEDIUM_TYPE, m);
    write_reg(ciep_pkg::CFG_MIN_LENGTH, n);
  endtask

  // add one byte at the end of the element
  task automatic append_byte(input logic [7:0] b);
    elem_bytes.insert(elem_bytes.size(), b);
  endtask

  // length byte counts the bytes after it
  task automatic fit_length();
    if (elem_bytes.size() >= 2) elem_bytes[1] = 8'(elem_bytes.size() - 2);
  endtask

  task automatic truncate_to(input int n);
    while (elem_bytes.size() > n) void'(elem_bytes.pop_back());
  endtask

  // element with the given fields and random content, length byte fitted to its size
  task automatic build_element(input logic [2:0] flags, input logic [7:0] clen_byte,
                               input int cdata_n, input int acts);
    elem_bytes.delete();
    append_byte(reg_type);
    append_byte(8'h00);
    append_byte(reg_medium);
    append_byte({1'($urandom_range(1)), flags, 4'($urandom_range(15))});
    if (flags[2]) repeat (MAC_LEN) append_byte(8'($urandom));
    if (flags[1]) begin
      append_byte(clen_byte);
      repeat (cdata_n) append_byte(8'($urandom));
    end
    if (flags[0]) repeat (PSM_LEN) append_byte(8'($urandom));
    repeat (acts) append_byte(8'($urandom));
    fit_length();
  endtask

  // registers at their reset values
  task automatic test_reset_values();
    elem_bytes = '{8'h00, 8'h03, 8'h00, 8'h0F, 8'hFF};
    send_element();
    elem_bytes = '{8'h00};
    send_element();
  endtask

  // elements that end inside the header, then one below the minimum length
  task automatic test_header_cut();
    write_all(8'h00, 8'hFF, 8'd0);
    elem_bytes = '{8'h00};
    send_element();
    elem_bytes = '{8'hFF};
    send_element();
    elem_bytes = '{8'h00, 8'h00};
    send_element();
    elem_bytes = '{8'h00, 8'h01, 8'hFF};
    send_element();
    elem_bytes = '{8'h00, 8'h02, 8'hFF, 8'h00};
    send_element();
    // minimum length at its top rejects every element shorter than 255 bytes
    write_reg(ciep_pkg::CFG_MIN_LENGTH, 8'hFF);
    build_element(3'b000, 8'h00, 0, 1);
    send_element();
  endtask

  // every field present, then an empty characteristic
  task automatic test_all_fields();
    write_all(8'hFF, 8'hFF, 8'd4);
    build_element(3'b111, 8'd2, 2, 2);
    elem_bytes[3] = 8'hFF;
    send_element();
    build_element(3'b011, 8'd0, 0, 1);
    send_element();
  endtask

  // each status from a field or header check
  task automatic test_field_errors();
    write_all(8'h5A, 8'hA5, 8'd4);
    build_element(3'b100, 8'h00, 0, 1);
    truncate_to(7);
    fit_length();
    send_element();
    build_element(3'b010, 8'd5, 5, 1);
    truncate_to(7);
    fit_length();
    send_element();
    build_element(3'b001, 8'h00, 0, 1);
    truncate_to(5);
    fit_length();
    send_element();
    build_element(3'b000, 8'h00, 0, 1);
    truncate_to(4);
    fit_length();
    send_element();
    // characteristic length with the sign bit set
    build_element(3'b010, 8'h80, 2, 1);
    send_element();
    build_element(3'b000, 8'h00, 0, 1);
    elem_bytes[0] = ~reg_type;
    send_element();
    // length byte with the sign bit set
    build_element(3'b000, 8'h00, 0, 1);
    elem_bytes[1] = 8'h80;
    send_element();
    build_element(3'b000, 8'h00, 0, 1);
    elem_bytes[2] = ~reg_medium;
    send_element();
    build_element(3'b101, 8'h00, 0, 2);
    elem_bytes[1] = elem_bytes[1] + 8'd1;
    send_element();
  endtask

  // byte count, offsets and counters run into saturation
  task automatic test_long_elements();
    build_element(3'b000, 8'h00, 0, 300);
    send_element();
    build_element(3'b010, 8'hFF, 200, 1);
    send_element();
  endtask

  // mostly well-formed elements, some broken ones and some noise
  task automatic test_random();
    int start;
    int pick;
    int n;
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: write_all(8'hFF, 8'h00, 8'd0);
        1: write_all(8'h00, 8'hFF, 8'd4);
        default: write_all(8'($urandom), 8'($urandom), 8'($urandom_range(12)));
      endcase
      steady = (k == 2);
      start = sent_items;
      while (sent_items - start < 150) begin
        pick = $urandom_range(99);
        if (pick < 85) begin
          build_element(3'($urandom_range(7)), 8'($urandom_range(10)), 0, $urandom_range(1, 4));
          if (elem_bytes.size() > 4 && elem_bytes[3][ciep_pkg::MASK_CHAR_BIT]) begin
            // fill the characteristic to its declared length
            n = 4 + (elem_bytes[3][ciep_pkg::MASK_MAC_BIT] ? MAC_LEN : 0);
            repeat (elem_bytes[n]) elem_bytes.insert(n + 1, 8'($urandom));
            fit_length();
          end
          if (pick >= 70) begin
            case ($urandom_range(5))
              0: elem_bytes[0] = elem_bytes[0] ^ 8'(1 << $urandom_range(7));
              1: elem_bytes[1] = 8'($urandom);
              2: elem_bytes[2] = elem_bytes[2] ^ 8'(1 << $urandom_range(7));
              3: truncate_to($urandom_range(1, elem_bytes.size() - 1));
              4: begin
                truncate_to($urandom_range(1, elem_bytes.size() - 1));
                fit_length();
              end
              default: append_byte(8'($urandom));
            endcase
          end
          send_element();
        end else if (pick < 95) begin
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++)
            send_byte(8'($urandom), (i == n - 1) || ($urandom_range(7) == 0));
        end else begin
          build_element(3'($urandom_range(7)) | 3'b010, 8'($urandom_range(128, 255)),
                        $urandom_range(6), $urandom_range(1, 3));
          send_element();
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_header_cut();
    test_all_fields();
    test_field_errors();
    test_long_elements();
    test_random();
    settle();
    repeat (4) @(posedge clk);
    if (expected_labels.size() != 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %0d labels never matched", $realtime, expected_labels.size());
    end
    if (mismatch_count == 0) begin
      $display("connection_info_element_parser_unit test passed");
    end else begin
      $display("connection_info_element_parser_unit test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("connection_info_element_parser_unit test failed");
    $finish;
  end

endmodule
